FILE: hdl/multirotor_position_pd_controller_macros.svh
// Assertion macros used by the block's checker
`ifndef MULTIROTOR_POSITION_PD_CONTROLLER_MACROS_SVH
`define MULTIROTOR_POSITION_PD_CONTROLLER_MACROS_SVH
`define MPPD_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define MPPD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

FILE: hdl/mppd_pkg.sv
// Package: types, constants and helper functions of the position controller
package mppd_pkg;
   localparam int DATA_WIDTH_DEFAULT = 32;
   localparam int SINE_DEPTH_DEFAULT = 256;

   localparam logic [1:0] CMD_Z = 2'd0;
   localparam logic [1:0] CMD_X = 2'd1;
   localparam logic [1:0] CMD_Y = 2'd2;
   localparam logic [1:0] CMD_NONE = 2'd3;

   localparam logic [2:0] REG_GAINS_X = 3'd0;
   localparam logic [2:0] REG_GAINS_Y = 3'd1;
   localparam logic [2:0] REG_GAINS_Z = 3'd2;
   localparam logic [2:0] REG_MASS = 3'd3;
   localparam logic [2:0] REG_GRAVITY = 3'd4;
   localparam logic [2:0] REG_GRAV_RECIP = 3'd5;
   localparam logic [2:0] REG_MIN_ACCEL = 3'd6;
   localparam logic [2:0] REG_MAX_ACCEL = 3'd7;

   localparam int REQ_TDATA_W = 176;
   localparam int RSP_TDATA_W = 144;
   localparam int RSP_TUSER_W = 4;

   // datapath operations
   localparam logic [3:0] OP_ERR = 4'd0;
   localparam logic [3:0] OP_ERRD = 4'd1;
   localparam logic [3:0] OP_MUL_KD = 4'd2;
   localparam logic [3:0] OP_MUL_KP = 4'd3;
   localparam logic [3:0] OP_ACC = 4'd4;
   localparam logic [3:0] OP_GRAV = 4'd5;
   localparam logic [3:0] OP_MUL_MASS = 4'd6;
   localparam logic [3:0] OP_MUL_XS = 4'd7;
   localparam logic [3:0] OP_MUL_YC = 4'd8;
   localparam logic [3:0] OP_MUL_XC = 4'd9;
   localparam logic [3:0] OP_MUL_YS = 4'd10;
   localparam logic [3:0] OP_ROLL = 4'd11;
   localparam logic [3:0] OP_PITCH = 4'd12;
   localparam logic [3:0] OP_LOAD = 4'd13;
   localparam logic [3:0] OP_NOP = 4'd15;

   typedef struct packed {
      logic [3:0] op;
      logic       load;
      logic       hold_x;
   } dp_cmd_type;

   localparam longint HALF_PI_Q30 = 64'd1686629713;

   function automatic int sine_quadrant(input longint unsigned x);
      longint unsigned x2;
      longint unsigned t;
      longint sum;
      x2 = (x * x) >> 30;
      t = x;
      sum = longint'(x);
      t = ((t * x2) >> 30) / 64'd6;
      sum = sum - longint'(t);
      t = ((t * x2) >> 30) / 64'd20;
      sum = sum + longint'(t);
      t = ((t * x2) >> 30) / 64'd42;
      sum = sum - longint'(t);
      t = ((t * x2) >> 30) / 64'd72;
      sum = sum + longint'(t);
      t = ((t * x2) >> 30) / 64'd110;
      sum = sum - longint'(t);
      t = ((t * x2) >> 30) / 64'd156;
      sum = sum + longint'(t);
      t = ((t * x2) >> 30) / 64'd210;
      sum = sum - longint'(t);
      if (sum < 0) sum = 0;
      return int'((longint'(sum) + 8192) >>> 14);
   endfunction

   function automatic int sine_entry(input int i, input int Depth);
      longint unsigned num;
      longint unsigned quad;
      longint unsigned rem;
      longint unsigned x;
      int v;
      num = 4 * longint'(i);
      quad = num / Depth;
      rem = num % Depth;
      x = (HALF_PI_Q30 * rem) / Depth;
      if (quad % 2 == 1) v = sine_quadrant(HALF_PI_Q30 - x);
      else v = sine_quadrant(x);
      return (quad >= 2) ? -v : v;
   endfunction
endpackage

FILE: hdl/mppd_datapath.sv
// Datapath: operand registers, saturating adder and shared multiplier
module mppd_datapath
   import mppd_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
   input  logic                   clock,
   input  logic                   reset,
   input  dp_cmd_type             cmd,
   input  logic [1:0]             req_cmd,
   input  logic [REQ_TDATA_W-1:0] req_data,
   input  logic [31:0]            gains_x,
   input  logic [31:0]            gains_y,
   input  logic [31:0]            gains_z,
   input  logic [30:0]            vehicle_mass,
   input  logic [30:0]            gravity_accel,
   input  logic [30:0]            gravity_reciprocal,
   input  logic signed [31:0]     min_accel,
   input  logic signed [31:0]     max_accel,
   output logic [1:0]             axis,
   output logic [RSP_TUSER_W-1:0] rsp_user,
   output logic [RSP_TDATA_W-1:0] rsp_data
);
   localparam int W = DATA_WIDTH;
   localparam int IW = $clog2(SINE_TABLE_DEPTH);
   localparam logic signed [W+1:0] HI = (W+2)'((longint'(1) <<< (W - 1)) - 1);
   localparam logic signed [W+1:0] LO = -HI - 1;

   logic signed [31:0] sine_rom [SINE_TABLE_DEPTH];
   for (genvar i = 0; i < SINE_TABLE_DEPTH; i++) begin : g_rom
      assign sine_rom[i] = 32'(sine_entry(i, SINE_TABLE_DEPTH));
   end

   logic [1:0] cmd_ff;
   logic signed [W-1:0] p_ff, v_ff, tp_ff, tv_ff, ff_ff;
   logic [15:0] yaw_ff;
   logic [31:0] gain_ff;
   logic signed [W-1:0] err_ff, errd_ff, acc_ff, t0_ff, t1_ff, t2_ff, t3_ff, x_ff;
   logic signed [W-1:0] thrust_ff, roll_ff, pitch_ff;
   logic signed [31:0] sin_ff, cos_ff;

   function automatic logic signed [W-1:0] sat_wide(input logic signed [63:0] e);
      if (e > 64'(HI)) return HI[W-1:0];
      if (e < 64'(LO)) return LO[W-1:0];
      return e[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_in(input logic [31:0] v);
      return sat_wide(64'($signed(v)));
   endfunction

   function automatic logic signed [W-1:0] sat2(input logic signed [W+1:0] e);
      logic signed [W+1:0] r;
      r = e;
      if (r > HI) r = HI;
      if (r < LO) r = LO;
      return r[W-1:0];
   endfunction

   // shared multiplier: a * b >> sh, floor, saturated
   logic signed [W-1:0]  mul_a;
   logic signed [32:0]   mul_b;
   logic                 mul_sh8;
   logic signed [W+33:0] prod;
   logic signed [W+33:0] shifted;
   logic signed [W-1:0]  mul_res;
   always_comb begin
      prod = (W+34)'(mul_a) * (W+34)'(mul_b);
      shifted = mul_sh8 ? (prod >>> 8) : (prod >>> 16);
      if (shifted > (W+34)'(HI)) mul_res = HI[W-1:0];
      else if (shifted < (W+34)'(LO)) mul_res = LO[W-1:0];
      else mul_res = shifted[W-1:0];
   end

   always_comb begin
      mul_a = err_ff;
      mul_b = 33'($signed({1'b0, gain_ff[15:0]}));
      mul_sh8 = 1'b1;
      unique case (cmd.op)
         OP_MUL_KD: begin
            mul_a = errd_ff;
            mul_b = 33'($signed({1'b0, gain_ff[31:16]}));
         end
         OP_MUL_MASS: begin
            mul_a = t0_ff;
            mul_b = 33'($signed({1'b0, vehicle_mass}));
            mul_sh8 = 1'b0;
         end
         OP_MUL_XS: begin
            mul_a = x_ff; mul_b = 33'(sin_ff); mul_sh8 = 1'b0;
         end
         OP_MUL_YC: begin
            mul_a = acc_ff; mul_b = 33'(cos_ff); mul_sh8 = 1'b0;
         end
         OP_MUL_XC: begin
            mul_a = x_ff; mul_b = 33'(cos_ff); mul_sh8 = 1'b0;
         end
         OP_MUL_YS: begin
            mul_a = acc_ff; mul_b = 33'(sin_ff); mul_sh8 = 1'b0;
         end
         OP_ROLL: begin
            mul_a = t0_ff;
            mul_b = 33'($signed({1'b0, gravity_reciprocal}));
            mul_sh8 = 1'b0;
         end
         OP_PITCH: begin
            mul_a = t2_ff;
            mul_b = 33'($signed({1'b0, gravity_reciprocal}));
            mul_sh8 = 1'b0;
         end
         default: ;
      endcase
   end

   logic [15:0] cos_ang;
   logic [IW-1:0] sin_idx, cos_idx;
   logic signed [W-1:0] acc_sum, lim_lo, lim_hi, acc_clamped;
   always_comb begin
      cos_ang = yaw_ff + 16'd16384;
      sin_idx = IW'((32'(yaw_ff) * SINE_TABLE_DEPTH) >> 16);
      cos_idx = IW'((32'(cos_ang) * SINE_TABLE_DEPTH) >> 16);
      acc_sum = sat2((W+2)'(ff_ff) + (W+2)'(t0_ff) + (W+2)'(t1_ff));
      lim_lo = sat_in(min_accel);
      lim_hi = sat_in(max_accel);
      acc_clamped = acc_sum;
      if (acc_clamped < lim_lo) acc_clamped = lim_lo;
      if (acc_clamped > lim_hi) acc_clamped = lim_hi;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= '0;
      end else if (cmd.hold_x) begin
         x_ff <= acc_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         cmd_ff <= req_cmd;
         p_ff <= sat_in(req_data[31:0]);
         v_ff <= sat_in(req_data[63:32]);
         tp_ff <= sat_in(req_data[95:64]);
         tv_ff <= sat_in(req_data[127:96]);
         ff_ff <= sat_in(req_data[159:128]);
         yaw_ff <= req_data[175:160];
         unique case (req_cmd)
            CMD_Z: gain_ff <= gains_z;
            CMD_X: gain_ff <= gains_x;
            default: gain_ff <= gains_y;
         endcase
         thrust_ff <= '0;
         roll_ff <= '0;
         pitch_ff <= '0;
      end
      unique case (cmd.op)
         OP_LOAD: begin
            sin_ff <= sine_rom[sin_idx];
            cos_ff <= sine_rom[cos_idx];
         end
         OP_ERR: err_ff <= sat2((W+2)'(tp_ff) - (W+2)'(p_ff));
         OP_ERRD: errd_ff <= sat2((W+2)'(tv_ff) - (W+2)'(v_ff));
         OP_MUL_KD: t0_ff <= mul_res;
         OP_MUL_KP: t1_ff <= mul_res;
         OP_ACC: acc_ff <= acc_clamped;
         OP_GRAV: t0_ff <= sat_wide(64'(acc_ff) + 64'($signed({1'b0, gravity_accel})));
         OP_MUL_MASS: thrust_ff <= mul_res;
         OP_MUL_XS: t0_ff <= mul_res;
         OP_MUL_YC: t1_ff <= mul_res;
         OP_MUL_XC: t2_ff <= mul_res;
         OP_MUL_YS: begin
            t3_ff <= mul_res;
            t0_ff <= sat2((W+2)'(t0_ff) - (W+2)'(t1_ff));
            t2_ff <= sat2((W+2)'(t2_ff) + (W+2)'(mul_res));
         end
         OP_ROLL: roll_ff <= mul_res;
         OP_PITCH: pitch_ff <= mul_res;
         default: ;
      endcase
   end

   assign axis = cmd_ff;

   always_comb begin
      rsp_user = {cmd_ff == CMD_Y, cmd_ff == CMD_Z, cmd_ff};
      rsp_data = '0;
      rsp_data[31:0] = 32'(acc_ff);
      rsp_data[63:32] = 32'(thrust_ff);
      rsp_data[95:64] = 32'(roll_ff);
      rsp_data[127:96] = 32'(pitch_ff);
      rsp_data[143:128] = (cmd_ff == CMD_Y) ? yaw_ff : 16'd0;
   end

   logic unused_t3;
   assign unused_t3 = ^t3_ff;
endmodule

FILE: hdl/mppd_control.sv
// Controller: sequences one item through the datapath
module mppd_control
   import mppd_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [1:0] req_cmd,
   input  logic [1:0] axis,
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output dp_cmd_type cmd
);
   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_RUN = 2'd1;
   localparam logic [1:0] S_OUT = 2'd2;

   logic [1:0] state_ff, state_in;
   logic [3:0] step_ff, step_in;
   logic accept;

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_OUT);
   assign accept = req_tvalid && req_tready;

   always_comb begin
      state_in = state_ff;
      step_in = step_ff;
      cmd.op = OP_NOP;
      cmd.load = accept;
      cmd.hold_x = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept && req_cmd != CMD_NONE) begin
               state_in = S_RUN;
               step_in = OP_LOAD;
            end
         end
         S_RUN: begin
            cmd.op = step_ff;
            priority if (step_ff == OP_LOAD) begin
               step_in = OP_ERR;
            end else if (step_ff == OP_ACC) begin
               priority if (axis == CMD_Z) step_in = OP_GRAV;
               else if (axis == CMD_Y) step_in = OP_MUL_XS;
               else state_in = S_OUT;
            end else if (step_ff == OP_MUL_MASS || step_ff == OP_PITCH) begin
               state_in = S_OUT;
            end else begin
               step_in = step_ff + 4'd1;
            end
         end
         S_OUT: begin
            if (rsp_tready) begin
               state_in = S_IDLE;
               cmd.hold_x = (axis == CMD_X);
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         step_ff <= OP_LOAD;
      end else begin
         state_ff <= state_in;
         step_ff <= step_in;
      end
   end
endmodule

FILE: hdl/multirotor_position_pd_controller.sv
// Top level: multirotor position PD controller
// One axis sample is taken at a time; x, z and y items take different walks of the
// controller through the one shared multiplier, the y walk the longest. The next
// sample can be taken the cycle after the result beat leaves. Command 3 is
// dropped with no result.
module multirotor_position_pd_controller
   import mppd_pkg::*;
#(
   parameter int DATA_WIDTH = DATA_WIDTH_DEFAULT,
   parameter int SINE_TABLE_DEPTH = SINE_DEPTH_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // command
   input  logic [1:0]  req_tuser,
   // position, velocity, target_position, target_velocity, feedforward, yaw
   input  logic [175:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // axis, thrust_valid, angles_valid
   output logic [3:0]  rsp_tuser,
   // accel_cmd, thrust, roll_cmd, pitch_cmd, yaw_cmd
   output logic [143:0] rsp_tdata,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_data
);
   logic [31:0] gains_x_ff, gains_y_ff, gains_z_ff;
   logic [30:0] mass_ff, grav_ff, recip_ff;
   logic signed [31:0] min_ff, max_ff;
   dp_cmd_type cmd;
   logic [1:0] axis;
   logic [RSP_TDATA_W-1:0] rsp_data;
   logic [RSP_TUSER_W-1:0] rsp_user;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         gains_x_ff <= '0;
         gains_y_ff <= '0;
         gains_z_ff <= '0;
         mass_ff <= 31'd65536;
         grav_ff <= 31'd642908;
         recip_ff <= 31'd6681;
         min_ff <= -32'sd642908;
         max_ff <= 32'sd642908;
      end else if (csr_valid) begin
         unique case (csr_index)
            REG_GAINS_X: gains_x_ff <= csr_data;
            REG_GAINS_Y: gains_y_ff <= csr_data;
            REG_GAINS_Z: gains_z_ff <= csr_data;
            REG_MASS: mass_ff <= csr_data[30:0];
            REG_GRAVITY: grav_ff <= csr_data[30:0];
            REG_GRAV_RECIP: recip_ff <= csr_data[30:0];
            REG_MIN_ACCEL: min_ff <= csr_data;
            REG_MAX_ACCEL: max_ff <= csr_data;
            default: ;
         endcase
      end
   end

   mppd_control u_control (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_cmd(req_tuser), .axis(axis),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .cmd(cmd)
   );

   mppd_datapath #(.DATA_WIDTH(DATA_WIDTH), .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)) u_datapath (
      .clock(clock), .reset(reset), .cmd(cmd), .req_cmd(req_tuser), .req_data(req_tdata),
      .gains_x(gains_x_ff), .gains_y(gains_y_ff), .gains_z(gains_z_ff),
      .vehicle_mass(mass_ff), .gravity_accel(grav_ff), .gravity_reciprocal(recip_ff),
      .min_accel(min_ff), .max_accel(max_ff), .axis(axis), .rsp_user(rsp_user),
      .rsp_data(rsp_data)
   );

   assign rsp_tdata = rsp_data;
   assign rsp_tuser = rsp_user;
endmodule

FILE: hdl/mppd_checker.sv
// Checker: port-level properties of the position controller
`include "multirotor_position_pd_controller_macros.svh"
module mppd_checker
   import mppd_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [3:0]   rsp_tuser,
   input logic [143:0] rsp_tdata
);
   `MPPD_ASSERT_IMPL(a_no_overlap, clock, reset, rsp_tvalid, !req_tready)
   `MPPD_ASSERT_IMPL(a_thrust_flag, clock, reset, rsp_tvalid,
      rsp_tuser[2] == (rsp_tuser[1:0] == CMD_Z))
   `MPPD_ASSERT_IMPL(a_angle_flag, clock, reset, rsp_tvalid,
      rsp_tuser[3] == (rsp_tuser[1:0] == CMD_Y))
   `MPPD_ASSERT_NEXT(a_hold, clock, reset, rsp_tvalid && !rsp_tready,
      rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
endmodule

bind multirotor_position_pd_controller mppd_checker u_checker (
   .clock(clock), .reset(reset), .req_tvalid(req_tvalid), .req_tready(req_tready),
   .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tuser(rsp_tuser),
   .rsp_tdata(rsp_tdata)
);
